FILE: sv/acir_pkg.sv
// ----------------------------------------------------------------------------
// acir_pkg
// Types, timing constants and code tables for the air-conditioner IR encoder.
// ----------------------------------------------------------------------------
package acir_pkg;

   localparam int FRAME_BITS = 28;
   localparam int DUR_W      = 14;
   localparam int STEP_LAST  = 2 * FRAME_BITS + 2;
   localparam int STEP_W     = $clog2(STEP_LAST + 1);

   localparam logic [7:0] SIGNATURE   = 8'h88;
   localparam logic [5:0] TEMP_OFFSET = 6'd15;

   localparam logic [DUR_W-1:0] HDR_MARK_A  = 14'd8500;
   localparam logic [DUR_W-1:0] HDR_SPACE_A = 14'd4250;
   localparam logic [DUR_W-1:0] HDR_MARK_B  = 14'd3200;
   localparam logic [DUR_W-1:0] HDR_SPACE_B = 14'd9900;
   localparam logic [DUR_W-1:0] BIT_MARK_A  = 14'd550;
   localparam logic [DUR_W-1:0] BIT_MARK_B  = 14'd480;
   localparam logic [DUR_W-1:0] SPACE_ONE   = 14'd1600;
   localparam logic [DUR_W-1:0] SPACE_ZERO  = 14'd550;

   typedef enum logic [1:0] {
      OP_STATE  = 2'd0,
      OP_TOGGLE = 2'd1,
      OP_EXTRA  = 2'd2
   } acir_opcode_type;

   typedef enum logic [1:0] {
      CSR_MODEL_VARIANT = 2'd0,
      CSR_TEMP_MIN      = 2'd1,
      CSR_TEMP_MAX      = 2'd2
   } acir_csr_type;

   typedef struct packed {
      logic                  err;
      logic                  variant;
      logic [FRAME_BITS-1:0] word;
   } acir_cmd_type;

   function automatic logic [2:0] mode_code(input logic [2:0] mode);
      logic [2:0] code;
      case (mode)
         3'd2:    code = 3'd3;
         3'd3:    code = 3'd1;
         3'd4:    code = 3'd4;
         3'd5:    code = 3'd2;
         default: code = 3'd0;
      endcase
      return code;
   endfunction

   function automatic logic [3:0] fan_code(input logic [2:0] fan);
      logic [3:0] code;
      case (fan)
         3'd1:    code = 4'd1;
         3'd2:    code = 4'd2;
         3'd3:    code = 4'd4;
         default: code = 4'd5;
      endcase
      return code;
   endfunction

   function automatic logic [FRAME_BITS-1:0] toggle_word(input logic [1:0] idx);
      logic [FRAME_BITS-1:0] w;
      case (idx)
         2'd0:    w = 28'h88C0051;
         2'd1:    w = 28'h8810001;
         default: w = 28'h88C00A6;
      endcase
      return w;
   endfunction

   function automatic logic [FRAME_BITS-1:0] extra_word(input logic [2:0] idx);
      logic [FRAME_BITS-1:0] w;
      case (idx)
         3'd0:    w = 28'h8813048;
         3'd1:    w = 28'h8813059;
         3'd2:    w = 28'h881306A;
         3'd3:    w = 28'h881307B;
         3'd4:    w = 28'h881308C;
         3'd5:    w = 28'h881309D;
         3'd6:    w = 28'h881316B;
         default: w = 28'h881317C;
      endcase
      return w;
   endfunction

endpackage

FILE: sv/acir_front.sv
// ----------------------------------------------------------------------------
// acir_front
// Holds the configuration registers, accepts requests, checks them and builds
// the frame word or an error command in one registered stage.
// ----------------------------------------------------------------------------
module acir_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [4:0]           csr_wdata,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [1:0]           req_opcode,
   input  logic [2:0]           req_mode,
   input  logic [2:0]           req_fan,
   input  logic [5:0]           req_temperature,
   input  logic [3:0]           req_button_index,
   output logic                 q_push,
   output acir_pkg::acir_cmd_type q_data,
   input  logic                 q_full
);
   import acir_pkg::*;

   logic         variant_ff, variant_in;
   logic [4:0]   temp_min_ff, temp_min_in;
   logic [4:0]   temp_max_ff, temp_max_in;
   logic         valid_ff, valid_in;
   acir_cmd_type cmd_ff, cmd_in;
   logic         accept;
   logic [5:0]   t_lo, t_sat, t_off;
   logic [3:0]   t_field, f_field, chk;
   logic [2:0]   m_field;
   logic [FRAME_BITS-1:0] state_w;

   assign q_push   = valid_ff && !q_full;
   assign req_full = valid_ff && !q_push;
   assign accept   = req_push && !req_full;
   assign q_data   = cmd_ff;

   always_comb begin
      variant_in  = variant_ff;
      temp_min_in = temp_min_ff;
      temp_max_in = temp_max_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MODEL_VARIANT: variant_in  = csr_wdata[0];
            CSR_TEMP_MIN:      temp_min_in = csr_wdata;
            CSR_TEMP_MAX:      temp_max_in = csr_wdata;
            default:           ;
         endcase
      end
   end

   always_comb begin
      t_lo    = (req_temperature < {1'b0, temp_min_ff}) ? {1'b0, temp_min_ff} : req_temperature;
      t_sat   = (t_lo > {1'b0, temp_max_ff}) ? {1'b0, temp_max_ff} : t_lo;
      t_off   = t_sat - TEMP_OFFSET;
      t_field = t_off[3:0];
      m_field = mode_code(req_mode);
      f_field = fan_code(req_fan);
      chk     = f_field + t_field + {1'b0, m_field};
      state_w = {SIGNATURE, 4'd0, 1'b0, m_field, t_field, f_field, chk};
   end

   always_comb begin
      cmd_in.variant = variant_ff;
      cmd_in.err     = 1'b1;
      cmd_in.word    = '0;
      case (req_opcode)
         OP_STATE: begin
            if (req_mode inside {[3'd1:3'd5]}) begin
               cmd_in.err  = 1'b0;
               cmd_in.word = state_w;
            end
         end
         OP_TOGGLE: begin
            if (req_button_index < 4'd3) begin
               cmd_in.err  = 1'b0;
               cmd_in.word = toggle_word(req_button_index[1:0]);
            end
         end
         OP_EXTRA: begin
            if (req_button_index < 4'd8) begin
               cmd_in.err  = 1'b0;
               cmd_in.word = extra_word(req_button_index[2:0]);
            end
         end
         default: ;
      endcase
   end

   assign valid_in = accept || (valid_ff && !q_push);

   always_ff @(posedge clock) begin
      if (reset) begin
         variant_ff  <= 1'b0;
         temp_min_ff <= 5'd16;
         temp_max_ff <= 5'd30;
         valid_ff    <= 1'b0;
      end else begin
         variant_ff  <= variant_in;
         temp_min_ff <= temp_min_in;
         temp_max_ff <= temp_max_in;
         valid_ff    <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

FILE: sv/acir_queue.sv
// ----------------------------------------------------------------------------
// acir_queue
// Small command queue between the front and the back.
// ----------------------------------------------------------------------------
module acir_queue #(
   parameter int DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  acir_pkg::acir_cmd_type wr_data,
   output logic                   full,
   input  logic                   pop,
   output acir_pkg::acir_cmd_type rd_data,
   output logic                   empty
);
   import acir_pkg::*;

   localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   acir_cmd_type mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: sv/acir_back.sv
// ----------------------------------------------------------------------------
// acir_back
// Serialises one command into header, bit and trailer durations, or one error
// item, one item a cycle through an output register while it is not stalled.
// ----------------------------------------------------------------------------
module acir_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_empty,
   input  acir_pkg::acir_cmd_type q_data,
   output logic                   q_pop,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [13:0]            rsp_duration_us,
   output logic                   rsp_is_mark,
   output logic                   rsp_last,
   output logic                   rsp_error
);
   import acir_pkg::*;

   logic                  active_ff, active_in;
   logic                  err_ff, variant_ff;
   logic [FRAME_BITS-1:0] word_ff;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic                  out_valid_ff, out_valid_in;
   logic [DUR_W-1:0]      dur_ff, dur_in;
   logic                  mark_ff, mark_in, last_ff, last_in, oerr_ff;
   logic                  out_free, emit, done, last_now;
   logic [DUR_W-1:0]      mark_len;

   assign out_free = !out_valid_ff || rsp_pop;
   assign emit     = active_ff && out_free;
   assign last_now = err_ff || (step_ff == STEP_W'(STEP_LAST));
   assign done     = emit && last_now;
   assign q_pop    = !q_empty && (!active_ff || done);
   assign mark_len = variant_ff ? BIT_MARK_B : BIT_MARK_A;

   always_comb begin
      last_in = last_now;
      if (err_ff) begin
         dur_in  = '0;
         mark_in = 1'b0;
      end else if (step_ff == '0) begin
         dur_in  = variant_ff ? HDR_MARK_B : HDR_MARK_A;
         mark_in = 1'b1;
      end else if (step_ff == STEP_W'(1)) begin
         dur_in  = variant_ff ? HDR_SPACE_B : HDR_SPACE_A;
         mark_in = 1'b0;
      end else if (step_ff[0]) begin
         dur_in  = word_ff[FRAME_BITS-1] ? SPACE_ONE : SPACE_ZERO;
         mark_in = 1'b0;
      end else begin
         dur_in  = mark_len;
         mark_in = 1'b1;
      end
   end

   always_comb begin
      active_in    = q_pop ? 1'b1 : (done ? 1'b0 : active_ff);
      step_in      = q_pop ? '0 : (emit ? step_ff + 1'b1 : step_ff);
      out_valid_in = emit ? 1'b1 : (rsp_pop ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         err_ff     <= q_data.err;
         variant_ff <= q_data.variant;
         word_ff    <= q_data.word;
      end else if (emit && step_ff[0] && step_ff != STEP_W'(1)) begin
         word_ff <= {word_ff[FRAME_BITS-2:0], 1'b0};
      end
      if (emit) begin
         dur_ff  <= dur_in;
         mark_ff <= mark_in;
         last_ff <= last_in;
         oerr_ff <= err_ff;
      end
   end

   assign rsp_empty       = !out_valid_ff;
   assign rsp_duration_us = dur_ff;
   assign rsp_is_mark     = mark_ff;
   assign rsp_last        = last_ff;
   assign rsp_error       = oerr_ff;

endmodule

FILE: sv/ac_remote_ir_frame_encoder.sv
// ----------------------------------------------------------------------------
// ac_remote_ir_frame_encoder
// Pulse-distance infrared encoder for a 28-bit air-conditioner frame.
// ----------------------------------------------------------------------------
// Requests enter through a queue-like port: an item is taken when req_push is
// high and req_full is low. Each accepted request produces 59 duration items
// on the rsp_ port (header mark and space, 28 mark/space pairs, trailing mark),
// or a single item with rsp_error set when it is rejected. An item is taken
// when rsp_pop is high and rsp_empty is low; rsp_last marks the end of a run.
// A run's first item passes the front register, queue, serialiser command
// register and output register. The serialiser emits one item a cycle and
// pops the next request with a run's last item, so rejected requests pass one
// per cycle. The front stage and the command queue hold further requests
// while a run is in progress. Configuration is to be written through csr_we,
// csr_index and csr_wdata only while the block is idle; the block does not
// enforce this. Reset empties the queue and the output register and restores
// the standard timings and the 16 to 30 degree limits. When the receiver
// stalls, the output item holds and the queue fills until req_full rises.
// ----------------------------------------------------------------------------
module ac_remote_ir_frame_encoder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [4:0]  csr_wdata,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_opcode,
   input  logic [2:0]  req_mode,
   input  logic [2:0]  req_fan,
   input  logic [5:0]  req_temperature,
   input  logic [3:0]  req_button_index,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [13:0] rsp_duration_us,
   output logic        rsp_is_mark,
   output logic        rsp_last,
   output logic        rsp_error
);
   import acir_pkg::*;

   logic         q_push, q_full, q_pop, q_empty;
   acir_cmd_type q_wr_data, q_rd_data;

   acir_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_opcode       (req_opcode),
      .req_mode         (req_mode),
      .req_fan          (req_fan),
      .req_temperature  (req_temperature),
      .req_button_index (req_button_index),
      .q_push           (q_push),
      .q_data           (q_wr_data),
      .q_full           (q_full)
   );

   acir_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (q_wr_data),
      .full    (q_full),
      .pop     (q_pop),
      .rd_data (q_rd_data),
      .empty   (q_empty)
   );

   acir_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_data          (q_rd_data),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_duration_us (rsp_duration_us),
      .rsp_is_mark     (rsp_is_mark),
      .rsp_last        (rsp_last),
      .rsp_error       (rsp_error)
   );

endmodule

FILE: sv/acir_checker.sv
// ----------------------------------------------------------------------------
// acir_checker
// Port-level checks for the IR frame encoder, bound to the top level.
// ----------------------------------------------------------------------------
module acir_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic [13:0] rsp_duration_us,
   input logic        rsp_is_mark,
   input logic        rsp_last,
   input logic        rsp_error
);

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("Result port not empty or input full after reset.");

   a_error_single: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_error |-> rsp_last)
      else $error("Error item is not the last item of its run.");

   a_error_blank: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_error |-> rsp_duration_us == 14'd0 && !rsp_is_mark)
      else $error("Error item carries a duration or a mark.");

   a_trailer_mark: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_error && rsp_last |-> rsp_is_mark &&
      (rsp_duration_us == 14'd550 || rsp_duration_us == 14'd480))
      else $error("Final item of a frame is not a bit mark.");

endmodule

bind ac_remote_ir_frame_encoder acir_checker u_acir_checker (
   .clock           (clock),
   .reset           (reset),
   .req_full        (req_full),
   .rsp_empty       (rsp_empty),
   .rsp_duration_us (rsp_duration_us),
   .rsp_is_mark     (rsp_is_mark),
   .rsp_last        (rsp_last),
   .rsp_error       (rsp_error)
);
